@@ sv/prc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// prc_pkg
// Shared types and constants of the palette range cycler: sizes, register
// indexes, stream function codes and the palette command interface.
// ----------------------------------------------------------------------------
package prc_pkg;

	// Number of cycle ranges held by the block.
	localparam int MAX_RANGES     = 4;
	// Palette depth; addresses wrap by masking, so this is a power of two.
	localparam int PALETTE_SIZE   = 256;
	// Range registers that exist on the configuration port.
	localparam int NUM_RANGE_REGS = 4;
	localparam int SMALL_TOTAL    = 16;
	localparam int BIG_THRESHOLD  = 3;

	localparam int PAL_AW  = $clog2(PALETTE_SIZE);
	localparam int RIDX_W  = $clog2(MAX_RANGES + 1);
	localparam int RSEL_W  = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
	localparam int SUM_W   = 9 + $clog2(MAX_RANGES + 1);

	localparam int COLOR_W = 24;
	localparam int TIME_W  = 32;
	localparam int TICKS_W = 16;
	localparam int NUM_W   = 9;
	localparam int FIRST_W = 8;
	localparam int TOTAL_W = 11;
	localparam int CFG_W   = 33;
	localparam int CFGI_W  = 3;

	// Configuration register indexes.
	localparam logic [CFGI_W-1:0] REG_CYCLE_COUNT = 3'd0;
	localparam logic [CFGI_W-1:0] REG_RANGE0      = 3'd1;

	// Stream function codes carried in tuser.
	typedef enum logic [1:0] {
		FN_LOAD  = 2'd0,
		FN_START = 2'd1,
		FN_FRAME = 2'd2,
		FN_READ  = 2'd3
	} func_t;

	// Commands from the controller to the palette memory unit.
	typedef enum logic [1:0] {
		CMD_NONE = 2'd0,
		CMD_LOAD = 2'd1,
		CMD_READ = 2'd2,
		CMD_ROT  = 2'd3
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [7:0]         addr;
		logic [COLOR_W-1:0] color;
		logic [NUM_W-1:0]   num;
	} pal_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} pal_stat_t;

endpackage
`default_nettype wire

@@ sv/prc_palette_rotator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// prc_palette_rotator
// Owns the palette memory. Performs single loads and reads, and rotates a
// range forward by one entry with a read-ahead, write-behind pipeline that
// moves one entry per cycle.
// ----------------------------------------------------------------------------
module prc_palette_rotator import prc_pkg::*; (
	input  wire                clk,
	input  wire                arst_n,
	input  pal_cmd_t           cmd,
	output pal_stat_t          stat,
	output logic [COLOR_W-1:0] rd_data
);

	typedef enum logic [1:0] {
		RS_IDLE = 2'b01,
		RS_MOVE = 2'b10
	} rot_state_t;

	logic [COLOR_W-1:0] mem [PALETTE_SIZE];
	logic [COLOR_W-1:0] rd_data_q;

	rot_state_t         state_q;
	logic [NUM_W-1:0]   left_q;
	logic               save_s1;
	logic               mv_v_s1;
	logic [PAL_AW-1:0]  mv_dst_s1;
	logic [PAL_AW-1:0]  src_q;
	logic [PAL_AW-1:0]  dst_q;
	logic [PAL_AW-1:0]  base_q;
	logic [COLOR_W-1:0] saved_q;

	logic               we;
	logic [PAL_AW-1:0]  wa;
	logic [COLOR_W-1:0] wd;
	logic               re;
	logic [PAL_AW-1:0]  ra;
	logic [9:0]         hi_sum;
	logic [PAL_AW-1:0]  hi_addr;
	logic               finish;

	assign hi_sum  = {2'b00, cmd.addr} + {1'b0, cmd.num} - 10'd1;
	assign hi_addr = hi_sum[PAL_AW-1:0];
	assign finish  = (state_q == RS_MOVE) && (left_q == '0) && !mv_v_s1;

	always_comb begin
		we = 1'b0;
		wa = '0;
		wd = '0;
		re = 1'b0;
		ra = '0;
		unique case (state_q)
			RS_IDLE: begin
				unique case (cmd.kind)
					CMD_LOAD: begin
						we = 1'b1;
						wa = cmd.addr[PAL_AW-1:0];
						wd = cmd.color;
					end
					CMD_READ: begin
						re = 1'b1;
						ra = cmd.addr[PAL_AW-1:0];
					end
					CMD_ROT: begin
						re = 1'b1;
						ra = hi_addr;
					end
					CMD_NONE: ;
				endcase
			end
			RS_MOVE: begin
				// The write trails the read by two addresses, so a read never
				// sees an entry that is still waiting to be written.
				if (mv_v_s1) begin
					we = 1'b1;
					wa = mv_dst_s1;
					wd = rd_data_q;
				end else if (left_q == '0) begin
					we = 1'b1;
					wa = base_q;
					wd = saved_q;
				end
				if (left_q != '0) begin
					re = 1'b1;
					ra = src_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rd_data_q <= mem[ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= RS_IDLE;
			left_q  <= '0;
			save_s1 <= 1'b0;
			mv_v_s1 <= 1'b0;
		end else begin
			unique case (state_q)
				RS_IDLE: begin
					if (cmd.kind == CMD_ROT) begin
						left_q  <= cmd.num - 9'd1;
						save_s1 <= 1'b1;
						mv_v_s1 <= 1'b0;
						state_q <= RS_MOVE;
					end
				end
				RS_MOVE: begin
					save_s1 <= 1'b0;
					if (left_q != '0) begin
						mv_v_s1 <= 1'b1;
						left_q  <= left_q - 9'd1;
					end else begin
						mv_v_s1 <= 1'b0;
					end
					if (finish) begin
						state_q <= RS_IDLE;
					end
				end
				default: state_q <= RS_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == RS_IDLE && cmd.kind == CMD_ROT) begin
			src_q  <= hi_addr - PAL_AW'(1);
			dst_q  <= hi_addr;
			base_q <= cmd.addr[PAL_AW-1:0];
		end else if (state_q == RS_MOVE) begin
			if (save_s1) begin
				saved_q <= rd_data_q;
			end
			if (left_q != '0) begin
				mv_dst_s1 <= dst_q;
				src_q     <= src_q - PAL_AW'(1);
				dst_q     <= dst_q - PAL_AW'(1);
			end
		end
	end

	assign stat.busy = (state_q == RS_MOVE);
	assign stat.done = finish;
	assign rd_data   = rd_data_q;

endmodule
`default_nettype wire

@@ sv/palette_range_cycler_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// palette_range_cycler_core
// Palette color cycler: a 256-entry RGB palette with up to four ranges that
// rotate forward by one entry on frame events once their period has elapsed.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on the s_ channel; tuser selects the function (load, start,
// frame event, read). Every accepted item yields exactly one result transfer
// on the m_ channel, held in an output register.
// Load, start and a frame event that processes no ranges go from idle to
// the result state; a read first passes a read state for the palette memory
// read. A frame event that processes the ranges scans each range in use,
// and waits in a rotate state for every range that rotates; the rotation
// moves one palette entry per cycle through the single write port of the
// palette memory.
// Items are taken one at a time: s_tready is high only while the controller
// is idle. A finished result may wait in the output register while the next
// item is accepted; a stalled receiver holds the block once a second result
// is ready.
// Reset clears timestamps, range registers, active flag and frame delay and
// sets the frame threshold to three; the palette is not cleared and needs
// no clearing pass. Configuration must be written while idle (unchecked).
// ----------------------------------------------------------------------------
module palette_range_cycler_core import prc_pkg::*; (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               s_tvalid,
	output logic              s_tready,
	// [7:0] entry_index, [31:8] entry_color, [63:32] now_time,
	// [64] activate, [65] update_busy
	input  wire  [71:0]       s_tdata,
	// [1:0] func
	input  wire  [1:0]        s_tuser,
	output logic              m_tvalid,
	input  wire               m_tready,
	// [0] changed, [8:1] range_first, [19:9] range_count, [43:20] read_color
	output logic [47:0]       m_tdata,
	input  wire               cfg_we,
	input  wire  [CFGI_W-1:0] cfg_index,
	input  wire  [CFG_W-1:0]  cfg_data
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SCAN = 5'b00010,
		ST_ROT  = 5'b00100,
		ST_READ = 5'b01000,
		ST_DONE = 5'b10000
	} ctl_state_t;

	ctl_state_t         state_q;
	logic [2:0]         cycle_count_q;
	logic [CFG_W-1:0]   range_word_q [MAX_RANGES];
	logic [TIME_W-1:0]  last_time_q  [MAX_RANGES];
	logic               cycling_on_q;
	logic [1:0]         frame_delay_q;
	logic [1:0]         frame_threshold_q;
	logic [TOTAL_W-1:0] total_colors_q;
	logic [RIDX_W-1:0]  r_q;
	logic [TIME_W-1:0]  now_q;
	logic               res_changed_q;
	logic [FIRST_W-1:0] res_first_q;
	logic [TOTAL_W-1:0] res_count_q;
	logic [COLOR_W-1:0] res_color_q;
	logic               m_tvalid_q;
	logic [47:0]        m_tdata_q;

	func_t              func;
	logic [7:0]         in_index;
	logic [COLOR_W-1:0] in_color;
	logic [TIME_W-1:0]  in_now;
	logic               in_act;
	logic               in_busy;
	logic               accept;

	logic [RIDX_W-1:0]  in_use;
	logic [RSEL_W-1:0]  rsel;
	logic [CFG_W-1:0]   cur_word;
	logic [TIME_W:0]    due;
	logic               hit;
	logic               scan_end;
	logic               rot_go;
	logic [SUM_W-1:0]   sum;
	logic [TOTAL_W-1:0] start_total;
	logic [1:0]         delay_inc;
	logic               frame_go;
	logic               load_out;

	pal_cmd_t           cmd;
	pal_stat_t          stat;
	logic [COLOR_W-1:0] rd_data;

	assign func     = func_t'(s_tuser);
	assign in_index = s_tdata[7:0];
	assign in_color = s_tdata[31:8];
	assign in_now   = s_tdata[63:32];
	assign in_act   = s_tdata[64];
	assign in_busy  = s_tdata[65];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		if (32'(cycle_count_q) > MAX_RANGES) begin
			in_use = RIDX_W'(MAX_RANGES);
		end else begin
			in_use = RIDX_W'(cycle_count_q);
		end
	end

	assign rsel     = r_q[RSEL_W-1:0];
	assign cur_word = range_word_q[rsel];
	assign due      = {1'b0, last_time_q[rsel]} + (TIME_W+1)'(cur_word[15:0]);
	assign hit      = ({1'b0, now_q} >= due);
	assign scan_end = (r_q == in_use);
	assign rot_go   = (state_q == ST_SCAN) && !scan_end && hit && (cur_word[24:16] > 9'd1);

	always_comb begin
		sum = '0;
		for (int r = 0; r < MAX_RANGES; r++) begin
			if (RIDX_W'(r) < in_use) begin
				sum = sum + SUM_W'(range_word_q[r][24:16]);
			end
		end
	end

	assign start_total = TOTAL_W'(sum);

	assign delay_inc = (frame_delay_q < 2'd3) ? (frame_delay_q + 2'd1) : frame_delay_q;
	assign frame_go  = cycling_on_q && (delay_inc >= frame_threshold_q) && !in_busy;
	assign load_out  = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);

	always_comb begin
		cmd.kind  = CMD_NONE;
		cmd.addr  = in_index;
		cmd.color = in_color;
		cmd.num   = cur_word[24:16];
		if (accept && func == FN_LOAD) begin
			cmd.kind = CMD_LOAD;
		end else if (accept && func == FN_READ) begin
			cmd.kind = CMD_READ;
		end else if (rot_go) begin
			cmd.kind = CMD_ROT;
			cmd.addr = cur_word[32:25];
		end
	end

	prc_palette_rotator u_rotator (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.stat    (stat),
		.rd_data (rd_data)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycle_count_q <= '0;
			for (int r = 0; r < MAX_RANGES; r++) begin
				range_word_q[r] <= '0;
			end
		end else if (cfg_we) begin
			if (cfg_index == REG_CYCLE_COUNT) begin
				cycle_count_q <= cfg_data[2:0];
			end
			for (int r = 0; r < MAX_RANGES; r++) begin
				if (r < NUM_RANGE_REGS && 32'(cfg_index) == 32'(REG_RANGE0) + r) begin
					range_word_q[r] <= cfg_data;
				end
			end
		end
	end

	// Controller and cycler state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= ST_IDLE;
			cycling_on_q      <= 1'b0;
			frame_delay_q     <= '0;
			frame_threshold_q <= 2'(BIG_THRESHOLD);
			total_colors_q    <= '0;
			r_q               <= '0;
			res_changed_q     <= 1'b0;
			m_tvalid_q        <= 1'b0;
			for (int r = 0; r < MAX_RANGES; r++) begin
				last_time_q[r] <= '0;
			end
		end else begin
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						res_changed_q <= 1'b0;
						unique case (func)
							FN_LOAD: state_q <= ST_DONE;
							FN_START: begin
								for (int r = 0; r < MAX_RANGES; r++) begin
									last_time_q[r] <= in_now;
								end
								total_colors_q <= start_total;
								frame_threshold_q <= (start_total <= TOTAL_W'(SMALL_TOTAL))
									? 2'd0 : 2'(BIG_THRESHOLD);
								cycling_on_q <= in_act;
								state_q      <= ST_DONE;
							end
							FN_FRAME: begin
								if (cycling_on_q) begin
									frame_delay_q <= frame_go ? 2'd0 : delay_inc;
								end
								if (frame_go) begin
									r_q     <= '0;
									state_q <= ST_SCAN;
								end else begin
									state_q <= ST_DONE;
								end
							end
							FN_READ: state_q <= ST_READ;
						endcase
					end
				end
				ST_SCAN: begin
					if (scan_end) begin
						state_q <= ST_DONE;
					end else begin
						if (hit) begin
							last_time_q[rsel] <= now_q;
							res_changed_q     <= 1'b1;
						end
						if (rot_go) begin
							state_q <= ST_ROT;
						end else begin
							r_q <= r_q + RIDX_W'(1);
						end
					end
				end
				ST_ROT: begin
					if (stat.done) begin
						r_q     <= r_q + RIDX_W'(1);
						state_q <= ST_SCAN;
					end
				end
				ST_READ: state_q <= ST_DONE;
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			now_q       <= in_now;
			res_first_q <= '0;
			res_count_q <= '0;
			res_color_q <= '0;
		end
		if (state_q == ST_READ) begin
			res_color_q <= rd_data;
		end
		if (state_q == ST_SCAN && scan_end && res_changed_q) begin
			res_first_q <= range_word_q[0][32:25];
			res_count_q <= total_colors_q;
		end
		if (load_out) begin
			m_tdata_q <= {4'b0000, res_color_q, res_count_q, res_first_q, res_changed_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef ASSERT_OFF
	a_rot_no_reissue: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROT |-> cmd.kind == CMD_NONE)
		else $error("palette command issued while a rotation runs");

	a_idle_rot_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !stat.busy)
		else $error("rotator busy while the controller is idle");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> r_q <= in_use)
		else $error("range scan ran past the ranges in use");

	a_unchanged_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[19:1] == '0)
		else $error("range fields set on a result without a change");
`endif

endmodule
`default_nettype wire

@@ test/tb_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for palette_range_cycler_core. A behavioral mirror of
// the palette, the range timestamps and the frame pacing predicts one result
// per accepted item; a monitor compares every result transfer field by field.
// Directed tests cover loads, reads, start, frame pacing, wrapping ranges and
// the period limit, then random phases with and without stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top import prc_pkg::*; ();

	typedef struct packed {
		func_t              func;
		logic [7:0]         idx;
		logic [COLOR_W-1:0] color;
		logic [TIME_W-1:0]  now;
		logic               act;
		logic               busy;
	} cycler_item_t;

	typedef struct packed {
		logic               changed;
		logic [FIRST_W-1:0] first;
		logic [TOTAL_W-1:0] count;
		logic [COLOR_W-1:0] color;
	} cycler_result_t;

	// Longest quiet stretch of a correct run: a frame event rotating every range
	// at the largest count, plus the longest gap on each side, taken four times.
	localparam int STUCK_LIMIT = 4 * (MAX_RANGES * (1 + 511 + 2) + 1 + 2 * 12);

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               s_tvalid  = 1'b0;
	logic               s_tready;
	logic [71:0]        s_tdata   = '0;
	logic [1:0]         s_tuser   = '0;
	logic               m_tvalid;
	logic               m_tready  = 1'b0;
	logic [47:0]        m_tdata;
	logic               cfg_we    = 1'b0;
	logic [CFGI_W-1:0]  cfg_index = '0;
	logic [CFG_W-1:0]   cfg_data  = '0;

	// Mirror of the block state and its registers.
	logic [COLOR_W-1:0] pal_mirror   [PALETTE_SIZE];
	logic [TIME_W-1:0]  stamp_mirror [MAX_RANGES];
	logic [CFG_W-1:0]   range_mirror [MAX_RANGES];
	logic [2:0]         count_mirror = '0;
	logic               active_mirror = 1'b0;
	logic [1:0]         delay_mirror = '0;
	logic [1:0]         thresh_mirror = 2'(BIG_THRESHOLD);
	logic [TOTAL_W-1:0] total_mirror = '0;

	cycler_result_t     reply_queue [$];
	cycler_result_t     head_reply;
	logic [TIME_W-1:0]  cur_time = '0;
	bit                 idle_on = 1'b1;
	int                 error_count = 0;
	int                 stall_left = 0;
	int                 quiet_cycles = 0;

	palette_range_cycler_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		foreach (stamp_mirror[r]) begin
			stamp_mirror[r] = '0;
			range_mirror[r] = '0;
		end
	end

	// Applies one accepted item to the mirror and returns the result it causes.
	function automatic cycler_result_t cycler_apply(input cycler_item_t it);
		cycler_result_t     res;
		int unsigned        used;
		logic [SUM_W-1:0]   sum;
		logic [32:0]        due;
		logic [NUM_W-1:0]   num;
		logic [7:0]         base;
		logic [COLOR_W-1:0] saved;
		res = '0;
		used = (count_mirror > MAX_RANGES) ? MAX_RANGES : count_mirror;
		case (it.func)
			FN_LOAD: begin
				pal_mirror[it.idx] = it.color;
			end
			FN_START: begin
				sum = '0;
				for (int r = 0; r < MAX_RANGES; r++)
					stamp_mirror[r] = it.now;
				for (int r = 0; r < used; r++)
					sum = sum + range_mirror[r][24:16];
				total_mirror = sum[TOTAL_W-1:0];
				thresh_mirror = (total_mirror <= SMALL_TOTAL) ? 2'd0 : 2'(BIG_THRESHOLD);
				active_mirror = it.act;
			end
			FN_FRAME: begin
				if (active_mirror) begin
					if (delay_mirror < 2'd3)
						delay_mirror = delay_mirror + 2'd1;
					if (delay_mirror >= thresh_mirror && !it.busy) begin
						for (int r = 0; r < used; r++) begin
							due = {1'b0, stamp_mirror[r]} + 33'(range_mirror[r][15:0]);
							if ({1'b0, it.now} >= due) begin
								stamp_mirror[r] = it.now;
								res.changed = 1'b1;
								num = range_mirror[r][24:16];
								base = range_mirror[r][32:25];
								// Move from the top of the range down, one entry at a time.
								if (num > 1) begin
									saved = pal_mirror[8'(base + num - 1)];
									for (int i = num - 1; i >= 1; i--)
										pal_mirror[8'(base + i)] = pal_mirror[8'(base + i - 1)];
									pal_mirror[base] = saved;
								end
							end
						end
						if (res.changed) begin
							res.first = range_mirror[0][32:25];
							res.count = total_mirror;
						end
						delay_mirror = 2'd0;
					end
				end
			end
			FN_READ: begin
				res.color = pal_mirror[it.idx];
			end
		endcase
		return res;
	endfunction

	function automatic logic [CFG_W-1:0] range_word(input logic [7:0] first,
			input logic [8:0] count, input logic [15:0] ticks);
		return {first, count, ticks};
	endfunction

	function automatic logic [CFG_W-1:0] random_range_word();
		logic [8:0]  count;
		logic [15:0] ticks;
		// Large ranges are slow to rotate, so they stay rare.
		count = ($urandom_range(0, 14) == 0) ? 9'($urandom_range(0, 511))
			: 9'($urandom_range(0, 8));
		ticks = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
		return range_word(8'($urandom), count, ticks);
	endfunction

	task automatic check_field(input string name, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (want_v !== got_v) begin
			$error("%s: expected %0h, got %0h", name, want_v, got_v);
			error_count++;
		end
	endtask

	// Result monitor and receiver stalls.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (reply_queue.size() == 0) begin
				$error("result transfer with no prediction waiting: %h", m_tdata);
				error_count++;
			end else begin
				head_reply = reply_queue.pop_front();
				check_field("changed", 32'(head_reply.changed), 32'(m_tdata[0]));
				check_field("range_first", 32'(head_reply.first), 32'(m_tdata[8:1]));
				check_field("range_count", 32'(head_reply.count), 32'(m_tdata[19:9]));
				check_field("read_color", 32'(head_reply.color), 32'(m_tdata[43:20]));
				check_field("padding", 32'd0, 32'(m_tdata[47:44]));
			end
		end
		if (stall_left != 0)
			stall_left--;
		else if (idle_on && $urandom_range(0, 5) == 0)
			stall_left = $urandom_range(1, 12);
		m_tready <= (stall_left == 0);
	end

	always @(posedge clk) begin
		if (!arst_n || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STUCK_LIMIT) begin
			$display("palette_range_cycler_core verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_item(input cycler_item_t it);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'd0, it.busy, it.act, it.now, it.color, it.idx};
		s_tuser  <= it.func;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		reply_queue.push_back(cycler_apply(it));
	endtask

	// Every field is random; the caller overrides the ones that matter.
	function automatic cycler_item_t noise_item(input func_t f);
		cycler_item_t it;
		it.func  = f;
		it.idx   = 8'($urandom);
		it.color = 24'($urandom);
		it.now   = $urandom;
		it.act   = 1'($urandom);
		it.busy  = 1'($urandom);
		return it;
	endfunction

	task automatic do_load(input logic [7:0] idx, input logic [COLOR_W-1:0] color);
		cycler_item_t it;
		it = noise_item(FN_LOAD);
		it.idx = idx;
		it.color = color;
		send_item(it);
	endtask

	task automatic do_read(input logic [7:0] idx);
		cycler_item_t it;
		it = noise_item(FN_READ);
		it.idx = idx;
		send_item(it);
	endtask

	task automatic do_start(input logic [TIME_W-1:0] now, input logic act);
		cycler_item_t it;
		it = noise_item(FN_START);
		it.now = now;
		it.act = act;
		send_item(it);
	endtask

	task automatic do_frame(input logic [TIME_W-1:0] now, input logic busy);
		cycler_item_t it;
		it = noise_item(FN_FRAME);
		it.now = now;
		it.busy = busy;
		send_item(it);
	endtask

	task automatic release_bus();
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		release_bus();
		while (reply_queue.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFGI_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_CYCLE_COUNT)
			count_mirror = data[2:0];
		else if (idx >= REG_RANGE0 && idx < REG_RANGE0 + NUM_RANGE_REGS)
			range_mirror[idx - REG_RANGE0] = data;
		@(posedge clk);
	endtask

	task automatic configure(input logic [2:0] count, input logic [CFG_W-1:0] w0,
			input logic [CFG_W-1:0] w1, input logic [CFG_W-1:0] w2,
			input logic [CFG_W-1:0] w3);
		drain();
		// Bits above the count field are don't-care and get random values.
		write_reg(REG_CYCLE_COUNT, {30'($urandom), count});
		write_reg(REG_RANGE0, w0);
		write_reg(REG_RANGE0 + 3'd1, w1);
		write_reg(REG_RANGE0 + 3'd2, w2);
		write_reg(REG_RANGE0 + 3'd3, w3);
	endtask

	// Every entry is loaded first so that no read or rotation sees an
	// unwritten one.
	task automatic test_palette_fill();
		for (int i = 0; i < PALETTE_SIZE; i++) begin
			if (i == 0)
				do_load(8'(i), 24'hFFFFFF);
			else if (i == PALETTE_SIZE - 1)
				do_load(8'(i), 24'h000000);
			else
				do_load(8'(i), 24'($urandom));
		end
		do_read(8'd0);
		do_read(8'd255);
	endtask

	task automatic test_inactive_cycler();
		configure(3'd0, '0, '0, '0, '0);
		do_start(32'd100, 1'b0);
		do_frame(32'd200, 1'b0);
		do_read(8'd255);
	endtask

	// One small range that wraps past the top of the palette.
	task automatic test_wrapping_range();
		configure(3'd1, range_word(8'd250, 9'd10, 16'd5), '0, '0, '0);
		do_start(32'd1000, 1'b1);
		do_frame(32'd1004, 1'b0);
		do_frame(32'd1005, 1'b0);
		do_frame(32'd2000, 1'b1);
		do_read(8'd250);
		do_read(8'd3);
	endtask

	// Count above the range limit, a single-color and an empty range, two
	// full-size ranges, a period that runs past the 32-bit time, frame pacing
	// with a saturating delay, and a start that keeps the delay.
	task automatic test_four_ranges();
		configure(3'd7, range_word(8'd0, 9'd1, 16'd0), range_word(8'h40, 9'd0, 16'd0),
			range_word(8'h80, 9'd511, 16'hFFFF), 33'h1_FFFF_FFFF);
		for (int k = 0; k < 3; k++)
			write_reg(3'(int'(REG_RANGE0) + NUM_RANGE_REGS + k), {$urandom, 1'($urandom)});
		do_start(32'hFFFF_FFF0, 1'b1);
		repeat (3) do_frame(32'hFFFF_FFFF, 1'b0);
		do_frame(32'd0, 1'b0);
		do_start(32'd0, 1'b1);
		repeat (2) do_frame(32'h0000_FFFF, 1'b0);
		repeat (4) do_frame(32'h0001_0000, 1'b1);
		do_frame(32'h0002_0000, 1'b0);
		do_read(8'h80);
		do_read(8'hFF);
	endtask

	task automatic random_phase(input int items);
		logic [CFG_W-1:0] words [MAX_RANGES];
		logic [2:0]       count;
		int               pick;
		count = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7))
			: 3'($urandom_range(1, 4));
		foreach (words[r])
			words[r] = random_range_word();
		configure(count, words[0], words[1], words[2], words[3]);
		if ($urandom_range(0, 2) == 0)
			cur_time = $urandom;
		do_start(cur_time, $urandom_range(0, 7) != 0);
		repeat (items) begin
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				cur_time = cur_time + $urandom_range(0, 12);
				do_frame(cur_time, $urandom_range(0, 5) == 0);
			end else if (pick < 55) begin
				do_frame($urandom, 1'($urandom));
			end else if (pick < 70) begin
				do_read(8'($urandom));
			end else if (pick < 88) begin
				do_load(8'($urandom), 24'($urandom));
			end else begin
				do_start(cur_time, $urandom_range(0, 5) != 0);
			end
		end
	endtask

	task automatic test_random_phases();
		repeat (2) random_phase(5);
	endtask

	task automatic test_steady_stream();
		idle_on = 1'b0;
		random_phase(7);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_palette_fill();
		test_inactive_cycler();
		test_wrapping_range();
		test_four_ranges();
		test_random_phases();
		test_steady_stream();
		drain();
		repeat (20) @(posedge clk);
		if (reply_queue.size() != 0) begin
			$error("%0d predicted results never arrived", reply_queue.size());
			error_count++;
		end
		if (error_count == 0)
			$display("palette_range_cycler_core verification clean");
		else
			$display("palette_range_cycler_core verification failed");
		$finish;
	end

endmodule
`default_nettype wire
